>>> hdl/bdq_pkg.sv
// Shared types and constants for the bounded double-ended queue.
`default_nettype none
package bdq_pkg;

  localparam int WORD_W = 32;
  localparam int CMD_W  = 3;
  localparam int CNT_W  = 5;

  typedef logic [CMD_W-1:0]         cmd_t;
  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  localparam cmd_t CMD_PUSH_FRONT = 3'd0;
  localparam cmd_t CMD_PUSH_REAR  = 3'd1;
  localparam cmd_t CMD_POP_FRONT  = 3'd2;
  localparam cmd_t CMD_POP_REAR   = 3'd3;
  localparam cmd_t CMD_PEEK       = 3'd4;

  localparam word_t EMPTY_WORD = -32'sd1;
  localparam cnt_t  CAP_RESET  = 5'd16;

endpackage
`default_nettype wire

>>> hdl/bdq_cmd_if.sv
// Command channel: operation code and word to insert.
`default_nettype none
interface bdq_cmd_if;
  import bdq_pkg::*;

  logic  valid;
  logic  ready;
  cmd_t  command;
  word_t data_value;

  modport source (output valid, output command, output data_value, input ready);
  modport sink   (input valid, input command, input data_value, output ready);
endinterface
`default_nettype wire

>>> hdl/bdq_rsp_if.sv
// Response channel: success flag and queue state after the operation.
`default_nettype none
interface bdq_rsp_if;
  import bdq_pkg::*;

  logic  valid;
  logic  ready;
  logic  success;
  word_t front_value;
  word_t rear_value;
  logic  is_empty;
  logic  is_full;
  cnt_t  entry_count;

  modport source (output valid, output success, output front_value, output rear_value,
                  output is_empty, output is_full, output entry_count, input ready);
  modport sink   (input valid, input success, input front_value, input rear_value,
                  input is_empty, input is_full, input entry_count, output ready);
endinterface
`default_nettype wire

>>> hdl/bdq_ram.sv
// Generic single-write, single-read RAM with registered read (old data on collision).
`default_nettype none
module bdq_ram #(
  parameter  int WIDTH  = 32,
  parameter  int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> hdl/bounded_double_ended_queue_core.sv
// Top level of the bounded double-ended queue of signed 32-bit words.
//
// Channels: cmd carries one command word (insert front, insert rear,
// delete front, delete rear, peek) with an optional word to insert; rsp
// returns one word per command: success flag, front and rear words (-1
// when empty), empty and full flags and the entry count after the command.
// cfg_wr_en/cfg_wr_data write the capacity; write only while idle.
//
// An accepted command passes the read stage (pend), then the response
// register. Throughput: one command per cycle while rsp drains; the
// pointer and count update in the accept cycle, so the next command only
// waits on the response register. Storage is two mirrored RAMs, one read
// port each, for the front and rear words; a write to the word being read
// in the same cycle is forwarded from a register.
//
// Reset (rst, synchronous): pointers and count cleared, capacity 16, no
// response pending. RAM contents are not cleared; a slot is read only
// after it was written. When rsp stalls, one response waits in the
// output register and one more in the read stage; cmd.ready then drops.
`default_nettype none
module bounded_double_ended_queue_core #(
  parameter int MAX_DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire bdq_pkg::cnt_t       cfg_wr_data,
  bdq_cmd_if.sink                  cmd,
  bdq_rsp_if.source                rsp
);
  import bdq_pkg::*;

  localparam int   PTR_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int   LIM_MAX = (MAX_DEPTH > 31) ? 31 : MAX_DEPTH;
  localparam cnt_t LIM_CAP = CNT_W'(LIM_MAX);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_DEPTH - 1);

  typedef logic [PTR_W-1:0] ptr_t;

  function automatic ptr_t ring_next(input ptr_t p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic ptr_t ring_prev(input ptr_t p);
    return (p == '0) ? PTR_LAST : p - 1'b1;
  endfunction

  // Architectural state
  cnt_t capacity;
  ptr_t front_ptr, front_ptr_next;
  ptr_t rear_ptr, rear_ptr_next;
  cnt_t count, count_next;

  // Read stage (one command between accept and response register)
  logic  pend;
  logic  pend_ok, pend_empty, pend_full;
  cnt_t  pend_count;
  logic  fwd_front, fwd_rear;
  word_t fwd_data;

  logic  accept, out_free;
  logic  is_ins;
  logic  ok;
  logic  wr_en;
  ptr_t  wr_addr;
  ptr_t  rd_front_addr, rd_rear_addr;
  word_t ram_front, ram_rear;
  cnt_t  limit;

  assign out_free  = !rsp.valid || rsp.ready;
  assign cmd.ready = !pend || out_free;
  assign accept    = cmd.valid && cmd.ready;

  // capacity above MAX_DEPTH saturates
  assign limit  = (capacity > LIM_CAP) ? LIM_CAP : capacity;
  assign is_ins = cmd.command inside {CMD_PUSH_FRONT, CMD_PUSH_REAR};

  always_comb begin
    front_ptr_next = front_ptr;
    rear_ptr_next  = rear_ptr;
    count_next     = count;
    ok             = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = rear_ptr;
    if (accept) begin
      case (cmd.command)
        CMD_PUSH_FRONT: begin
          if (count < limit) begin
            front_ptr_next = ring_prev(front_ptr);
            wr_addr        = ring_prev(front_ptr);
            wr_en          = 1'b1;
            count_next     = count + 1'b1;
            ok             = 1'b1;
          end
        end
        CMD_PUSH_REAR: begin
          if (count < limit) begin
            rear_ptr_next = ring_next(rear_ptr);
            wr_en         = 1'b1;
            count_next    = count + 1'b1;
            ok            = 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          if (count != '0) begin
            front_ptr_next = ring_next(front_ptr);
            count_next     = count - 1'b1;
            ok             = 1'b1;
          end
        end
        CMD_POP_REAR: begin
          if (count != '0) begin
            rear_ptr_next = ring_prev(rear_ptr);
            count_next    = count - 1'b1;
            ok            = 1'b1;
          end
        end
        CMD_PEEK: begin
          ok = 1'b1;
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end
  end

  // Always read the words the current (or just updated) pointers name, so
  // a held response keeps seeing valid data.
  assign rd_front_addr = front_ptr_next;
  assign rd_rear_addr  = ring_prev(rear_ptr_next);

  bdq_ram #(.WIDTH(WORD_W), .DEPTH(MAX_DEPTH)) u_front_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (cmd.data_value),
    .rd_addr (rd_front_addr),
    .rd_data (ram_front)
  );

  bdq_ram #(.WIDTH(WORD_W), .DEPTH(MAX_DEPTH)) u_rear_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (cmd.data_value),
    .rd_addr (rd_rear_addr),
    .rd_data (ram_rear)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      front_ptr <= '0;
      rear_ptr  <= '0;
      count     <= '0;
      pend      <= 1'b0;
      fwd_front <= 1'b0;
      fwd_rear  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      front_ptr <= front_ptr_next;
      rear_ptr  <= rear_ptr_next;
      count     <= count_next;

      // RAM returns old data on a same-cycle write; bypass it
      fwd_front <= wr_en && (wr_addr == rd_front_addr);
      fwd_rear  <= wr_en && (wr_addr == rd_rear_addr);

      if (accept) begin
        pend <= 1'b1;
      end else if (out_free) begin
        pend <= 1'b0;
      end

      if (pend && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= cmd.data_value;
    if (accept) begin
      pend_ok    <= ok;
      pend_count <= count_next;
      pend_empty <= (count_next == '0);
      pend_full  <= (count_next >= limit);
    end
    if (pend && out_free) begin
      rsp.success     <= pend_ok;
      rsp.is_empty    <= pend_empty;
      rsp.is_full     <= pend_full;
      rsp.entry_count <= pend_count;
      rsp.front_value <= pend_empty ? EMPTY_WORD : (fwd_front ? fwd_data : ram_front);
      rsp.rear_value  <= pend_empty ? EMPTY_WORD : (fwd_rear ? fwd_data : ram_rear);
    end
  end

  // Ring invariant: rear sits count slots after front, wrapping at most once.
  a_ring: assert property (@(posedge clk) disable iff (rst)
    ((int'(front_ptr) + int'(count)) == int'(rear_ptr)) ||
    ((int'(front_ptr) + int'(count)) == (int'(rear_ptr) + MAX_DEPTH)))
    else $error("ring pointers out of step with count");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= MAX_DEPTH)
    else $error("count beyond storage depth");

  a_full_insert: assert property (@(posedge clk) disable iff (rst)
    accept && is_ins && (count >= limit) |=> $stable(count))
    else $error("insert into full queue changed count");

  a_held: assert property (@(posedge clk) disable iff (rst)
    pend && !out_free |=> pend)
    else $error("pending response dropped while output stalled");

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count))
    else $error("count moved without a command");

endmodule
`default_nettype wire

>>> dv/bounded_double_ended_queue_core_test.sv
// Self-checking testbench for the bounded double-ended queue core.
`timescale 1ns / 100ps

module bounded_double_ended_queue_core_test;
  import bdq_pkg::*;

  localparam int    DEPTH       = 16;
  localparam word_t WORD_MAX    = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN    = 32'sh8000_0000;
  // codes 5 to 7 are not operations: no change, success low
  localparam cmd_t  CMD_SPARE_FIRST = 3'd5;
  localparam cmd_t  CMD_SPARE_LAST  = 3'd7;
  localparam int    MAX_REPORTS = 40;

  // One response word as seen on rsp, or as predicted.
  typedef struct {
    logic  success;
    word_t front_value;
    word_t rear_value;
    logic  is_empty;
    logic  is_full;
    cnt_t  entry_count;
  } deque_state_t;

  // Shadow copy of the deque: applies each accepted command to its own ring,
  // queues the state that the response must report, and checks responses
  // against the oldest queued state.
  class deque_shadow;
    word_t        slots [DEPTH];
    int           head;      // index of the front word
    int           tail;      // slot after the rear word
    int           held;
    int           capacity;
    deque_state_t due_states [$];
    int           mismatches;
    int           checked;
    int           inserts, deletes, peeks, spares, refused, full_seen;

    function new();
      capacity = int'(CAP_RESET);
    endfunction

    function void set_capacity(cnt_t value);
      capacity = int'(value);
    endfunction

    function int step_back(int idx);
      return (idx == 0) ? DEPTH - 1 : idx - 1;
    endfunction

    function int step_on(int idx);
      return (idx == DEPTH - 1) ? 0 : idx + 1;
    endfunction

    function int pending();
      return due_states.size();
    endfunction

    function void note_command(cmd_t op, word_t value);
      deque_state_t due;
      int           limit;
      // capacities above the ring size saturate at the ring size
      limit = (capacity > DEPTH) ? DEPTH : capacity;
      due.success = 1'b0;
      case (op)
        CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
          inserts++;
          if (held < limit) begin
            if (op == CMD_PUSH_FRONT) begin
              head = step_back(head);
              slots[head] = value;
            end else begin
              slots[tail] = value;
              tail = step_on(tail);
            end
            held++;
            due.success = 1'b1;
          end
        end
        CMD_POP_FRONT, CMD_POP_REAR: begin
          deletes++;
          if (held > 0) begin
            if (op == CMD_POP_FRONT) head = step_on(head);
            else tail = step_back(tail);
            held--;
            due.success = 1'b1;
          end
        end
        CMD_PEEK: begin
          peeks++;
          due.success = 1'b1;
        end
        default: spares++;
      endcase
      if (!due.success && op <= CMD_POP_REAR) refused++;
      due.is_empty    = (held == 0);
      due.is_full     = (held >= limit);
      due.front_value = due.is_empty ? EMPTY_WORD : slots[head];
      due.rear_value  = due.is_empty ? EMPTY_WORD : slots[step_back(tail)];
      due.entry_count = cnt_t'(held);
      if (due.is_full && held != 0) full_seen++;
      due_states.insert(due_states.size(), due);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, logic [WORD_W-1:0] seen, logic [WORD_W-1:0] want);
      if (seen !== want)
        report_mismatch($sformatf("response %0d %s: got %0h, expected %0h",
                                  checked, name, seen, want));
    endtask

    task check_response(deque_state_t seen);
      deque_state_t want;
      if (due_states.size() == 0) begin
        report_mismatch("response word with no command outstanding");
        return;
      end
      want = due_states[0];
      due_states.delete(0);
      compare_field("success", WORD_W'(seen.success), WORD_W'(want.success));
      compare_field("front_value", seen.front_value, want.front_value);
      compare_field("rear_value", seen.rear_value, want.rear_value);
      compare_field("is_empty", WORD_W'(seen.is_empty), WORD_W'(want.is_empty));
      compare_field("is_full", WORD_W'(seen.is_full), WORD_W'(want.is_full));
      compare_field("entry_count", WORD_W'(seen.entry_count), WORD_W'(want.entry_count));
      checked++;
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  cnt_t        cfg_wr_data;
  int          send_gap_pct;    // chance per cycle that the command side idles
  int          recv_stall_pct;  // chance per cycle that rsp.ready is low
  deque_shadow shadow;

  bdq_cmd_if cmd_ch ();
  bdq_rsp_if rsp_ch ();

  bounded_double_ended_queue_core #(
    .MAX_DEPTH (DEPTH)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd_ch),
    .rsp         (rsp_ch)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("bounded_double_ended_queue_core_test failed");
    $finish;
  end

  // Response side: values are sampled as they stood before the edge, then
  // ready is redrawn for the next cycle.
  always @(posedge clk) begin : rsp_monitor
    deque_state_t seen;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      seen.success     = rsp_ch.success;
      seen.front_value = rsp_ch.front_value;
      seen.rear_value  = rsp_ch.rear_value;
      seen.is_empty    = rsp_ch.is_empty;
      seen.is_full     = rsp_ch.is_full;
      seen.entry_count = rsp_ch.entry_count;
      shadow.check_response(seen);
    end
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Presents one command word and returns at the edge that takes it. Valid
  // stays high on return, so back-to-back words need no extra cycle; the
  // caller or the next idle gap lowers it.
  task automatic send_command(cmd_t op, word_t value);
    while ($urandom_range(99) < send_gap_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.command    <= op;
    cmd_ch.data_value <= value;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    shadow.note_command(op, value);
  endtask

  // Stops the command side and waits for every response to come back.
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Capacity is only rewritten with the core idle.
  task automatic write_capacity(cnt_t value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow.set_capacity(value);
  endtask

  // Mostly random words, with the extremes and the empty marker mixed in.
  function automatic word_t pick_word();
    case ($urandom_range(15))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return EMPTY_WORD;
      3:       return '0;
      default: return word_t'($urandom);
    endcase
  endfunction

  // Random traffic at one capacity and one pacing mode. The insert bias is
  // redrawn every 40 words so the queue swings between draining, hovering
  // and filling up, which exercises both refusal paths and pointer wrap.
  task automatic random_phase(cnt_t cap, int gap_pct, int stall_pct, int count);
    int   insert_bias;
    int   roll;
    cmd_t op;
    write_capacity(cap);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    insert_bias    = 50;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) insert_bias = 20 + 30 * $urandom_range(2);
      roll = $urandom_range(99);
      if (roll < 3)
        op = cmd_t'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
      else if (roll < 9)
        op = CMD_PEEK;
      else if ($urandom_range(99) < insert_bias)
        op = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
      else
        op = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_REAR;
      send_command(op, pick_word());
    end
  endtask

  initial begin
    shadow            = new();
    rst               = 1'b1;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = CAP_RESET;
    cmd_ch.valid      = 1'b0;
    cmd_ch.command    = CMD_PEEK;
    cmd_ch.data_value = '0;
    send_gap_pct      = 0;
    recv_stall_pct    = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty queue first - peek, both deletes refused, unused codes.
    write_capacity(CAP_RESET);
    send_command(CMD_PEEK, pick_word());
    send_command(CMD_POP_FRONT, pick_word());
    send_command(CMD_POP_REAR, pick_word());
    for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
      send_command(cmd_t'(c), WORD_MAX);
    // Extreme words at both ends, including one equal to the empty marker,
    // then delete from both ends until one delete too many.
    send_command(CMD_PUSH_FRONT, WORD_MAX);
    send_command(CMD_PUSH_REAR, WORD_MIN);
    send_command(CMD_PUSH_FRONT, EMPTY_WORD);
    send_command(CMD_PUSH_REAR, '0);
    send_command(CMD_PEEK, pick_word());
    send_command(CMD_POP_REAR, pick_word());
    send_command(CMD_POP_FRONT, pick_word());
    send_command(CMD_POP_FRONT, pick_word());
    send_command(CMD_POP_REAR, pick_word());
    send_command(CMD_POP_FRONT, pick_word());
    // Capacity two: fill, then one insert refused on full.
    write_capacity(5'd2);
    send_command(CMD_PUSH_REAR, pick_word());
    send_command(CMD_PUSH_FRONT, pick_word());
    send_command(CMD_PUSH_REAR, pick_word());
    // Capacity lowered below the count: contents kept, full, deletes work.
    write_capacity(5'd1);
    send_command(CMD_PEEK, pick_word());
    send_command(CMD_PUSH_FRONT, pick_word());
    send_command(CMD_POP_REAR, pick_word());
    send_command(CMD_POP_REAR, pick_word());
    // Capacity zero: empty and full at once, every insert refused.
    write_capacity(5'd0);
    send_command(CMD_PUSH_FRONT, pick_word());
    send_command(CMD_PUSH_REAR, pick_word());
    send_command(CMD_PEEK, pick_word());

    // Random part: capacities across the field, including zero and values
    // beyond the ring size, each under one of four handshake pacings.
    random_phase(5'd16, 0, 0, 240);
    random_phase(5'd4, 82, 0, 230);
    random_phase(5'd1, 0, 82, 230);
    random_phase(5'd31, 22, 22, 240);
    random_phase(5'd7, 0, 0, 230);
    random_phase(5'd0, 82, 0, 120);
    random_phase(5'd17, 0, 82, 240);
    random_phase(5'd12, 22, 22, 240);

    // Drain, then leave room for any stray response word.
    settle();
    repeat (8) @(posedge clk);

    $display("covered %0d commands: %0d inserts, %0d deletes, %0d peeks, %0d unused codes",
             shadow.inserts + shadow.deletes + shadow.peeks + shadow.spares,
             shadow.inserts, shadow.deletes, shadow.peeks, shadow.spares);
    $display("%0d responses checked over 12 capacity writes; %0d refused, full %0d times",
             shadow.checked, shadow.refused, shadow.full_seen);
    if (shadow.mismatches == 0) begin
      $display("bounded_double_ended_queue_core_test passed");
    end else begin
      $display("bounded_double_ended_queue_core_test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/bdq_pkg.sv
hdl/bdq_cmd_if.sv
hdl/bdq_rsp_if.sv
hdl/bdq_ram.sv
hdl/bounded_double_ended_queue_core.sv
dv/bounded_double_ended_queue_core_test.sv
